// ----- hw/rtl/mtts_pkg.sv -----
// Shared types and constants for the multi-timer tick scheduler.
// No dependencies; used by the controller, datapath and top level.
package mtts_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OP_W   = 3;
    localparam int SEL_W  = 3;
    localparam int IVL_W  = 16;
    localparam int CNT_W  = 32;
    localparam int MASK_W = 8;
    localparam int MASK_IW = $clog2(MASK_W);
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_START  = 3'd2,
        OP_STOP   = 3'd3,
        OP_DELETE = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2,
        S_RESP = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic scan_last;
    } dp_stat_t;

endpackage

// ----- hw/rtl/multi_timer_tick_scheduler.sv -----
// Top level of the multi-timer tick scheduler.
// Depends on mtts_pkg, mtts_ctrl and mtts_dp.
//
// A transaction is taken when start is high and busy is low; every transaction
// returns one result on fired_mask and status, marked by done for exactly one
// cycle, and the receiver cannot stall it. A slot command (create, start, stop,
// delete or an unused opcode) passes the execute state and then raises done in
// the response state; no new transaction is accepted before done. A tick adds,
// between execute and response, the scan that checks one timer slot per cycle
// against the tick count. busy is low again in the cycle after done.
module multi_timer_tick_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mtts_pkg::OP_W-1:0]     opcode,
    input  logic [mtts_pkg::SEL_W-1:0]    slot,
    input  logic                          periodic,
    input  logic [mtts_pkg::IVL_W-1:0]    interval,
    output logic                          done,
    output logic [mtts_pkg::MASK_W-1:0]   fired_mask,
    output logic [mtts_pkg::STAT_W-1:0]   status
);

    mtts_pkg::dp_cmd_t  dp_cmd;
    mtts_pkg::dp_stat_t dp_stat;

    mtts_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd),
        .busy    (busy),
        .done    (done)
    );

    mtts_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .opcode     (opcode),
        .slot       (slot),
        .periodic   (periodic),
        .interval   (interval),
        .fired_mask (fired_mask),
        .status     (status)
    );

endmodule

// ----- hw/rtl/mtts_ctrl.sv -----
// Controller state machine for the multi-timer tick scheduler.
// Depends on mtts_pkg; drives the datapath through dp_cmd_t.
module mtts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mtts_pkg::dp_stat_t dp_stat,
    output mtts_pkg::dp_cmd_t  dp_cmd,
    output logic               busy,
    output logic               done
);

    mtts_pkg::state_t state_reg;
    mtts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = mtts_pkg::S_EXEC;
                end
            end
            mtts_pkg::S_EXEC:
            begin
                state_next = dp_stat.is_tick ? mtts_pkg::S_SCAN : mtts_pkg::S_RESP;
            end
            mtts_pkg::S_SCAN:
            begin
                if (dp_stat.scan_last)
                begin
                    state_next = mtts_pkg::S_RESP;
                end
            end
            mtts_pkg::S_RESP:
            begin
                state_next = mtts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mtts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd.capture   = (state_reg == mtts_pkg::S_IDLE) && start;
        dp_cmd.exec      = (state_reg == mtts_pkg::S_EXEC);
        dp_cmd.scan_step = (state_reg == mtts_pkg::S_SCAN);
        busy             = (state_reg != mtts_pkg::S_IDLE);
        done             = (state_reg == mtts_pkg::S_RESP);
    end

    // every accepted transaction leads to a result, then back to idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted transaction did not enter execution");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after result strobe");

    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.exec |=> !dp_cmd.exec)
        else $error("execute step repeated");

endmodule

// ----- hw/rtl/mtts_dp.sv -----
// Datapath for the multi-timer tick scheduler: slot table, tick counter, scan.
// Depends on mtts_pkg; sequenced by mtts_ctrl through dp_cmd_t.
module mtts_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtts_pkg::dp_cmd_t             dp_cmd,
    output mtts_pkg::dp_stat_t            dp_stat,
    input  logic [mtts_pkg::OP_W-1:0]     opcode,
    input  logic [mtts_pkg::SEL_W-1:0]    slot,
    input  logic                          periodic,
    input  logic [mtts_pkg::IVL_W-1:0]    interval,
    output logic [mtts_pkg::MASK_W-1:0]   fired_mask,
    output logic [mtts_pkg::STAT_W-1:0]   status
);

    logic [mtts_pkg::OP_W-1:0]    op_reg;
    logic [mtts_pkg::SEL_W-1:0]   sel_reg;
    logic                         per_reg;
    logic [mtts_pkg::IVL_W-1:0]   ivl_reg;

    logic [mtts_pkg::CNT_W-1:0]   tick_reg;
    logic [mtts_pkg::CNT_W-1:0]   tick_next;
    logic [mtts_pkg::SLOTS-1:0]   valid_reg;
    logic [mtts_pkg::SLOTS-1:0]   valid_next;
    logic [mtts_pkg::SLOTS-1:0]   running_reg;
    logic [mtts_pkg::SLOTS-1:0]   running_next;
    logic [mtts_pkg::SLOTS-1:0]   periodic_reg;
    logic [mtts_pkg::SLOTS-1:0]   periodic_next;
    logic [mtts_pkg::SLOT_W-1:0]  idx_reg;
    logic [mtts_pkg::SLOT_W-1:0]  idx_next;
    logic [mtts_pkg::MASK_W-1:0]  mask_reg;
    logic [mtts_pkg::MASK_W-1:0]  mask_next;
    mtts_pkg::status_t            status_reg;
    mtts_pkg::status_t            status_next;

    logic [mtts_pkg::IVL_W-1:0]   ivl_mem [mtts_pkg::SLOTS];
    logic [mtts_pkg::CNT_W-1:0]   due_mem [mtts_pkg::SLOTS];
    logic [mtts_pkg::IVL_W-1:0]   ivl_rd_reg;
    logic [mtts_pkg::CNT_W-1:0]   due_rd_reg;

    logic [mtts_pkg::SLOT_W-1:0]  sidx;
    logic                         slot_ok;
    logic                         wr_create;
    logic                         reload;
    logic                         hit;
    logic [mtts_pkg::CNT_W-1:0]   diff;

    assign sidx    = mtts_pkg::SLOT_W'(sel_reg);
    assign slot_ok = (32'(sel_reg) < mtts_pkg::SLOTS);
    assign diff    = tick_reg - due_rd_reg;
    assign hit     = valid_reg[idx_reg] && running_reg[idx_reg] && !diff[mtts_pkg::CNT_W-1];

    assign dp_stat.is_tick   = (op_reg == mtts_pkg::OP_TICK);
    assign dp_stat.scan_last = (idx_reg == mtts_pkg::SLOT_W'(mtts_pkg::SLOTS - 1));

    assign fired_mask = mask_reg;
    assign status     = status_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg  <= opcode;
            sel_reg <= slot;
            per_reg <= periodic;
            ivl_reg <= interval;
        end
    end

    always_comb
    begin
        tick_next     = tick_reg;
        valid_next    = valid_reg;
        running_next  = running_reg;
        periodic_next = periodic_reg;
        idx_next      = idx_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        wr_create     = 1'b0;
        reload        = 1'b0;
        if (dp_cmd.exec)
        begin
            mask_next   = '0;
            status_next = mtts_pkg::ST_OK;
            idx_next    = '0;
            case (op_reg)
                mtts_pkg::OP_CREATE:
                begin
                    if (!slot_ok)
                    begin
                        status_next = mtts_pkg::ST_EMPTY;
                    end
                    else if (valid_reg[sidx])
                    begin
                        status_next = mtts_pkg::ST_OCCUPIED;
                    end
                    else
                    begin
                        valid_next[sidx]    = 1'b1;
                        running_next[sidx]  = 1'b0;
                        periodic_next[sidx] = per_reg;
                        wr_create           = 1'b1;
                    end
                end
                mtts_pkg::OP_START, mtts_pkg::OP_STOP, mtts_pkg::OP_DELETE:
                begin
                    if (!slot_ok || !valid_reg[sidx])
                    begin
                        status_next = mtts_pkg::ST_EMPTY;
                    end
                    else if (op_reg == mtts_pkg::OP_START)
                    begin
                        running_next[sidx] = 1'b1;
                    end
                    else if (op_reg == mtts_pkg::OP_STOP)
                    begin
                        running_next[sidx] = 1'b0;
                    end
                    else
                    begin
                        valid_next[sidx]   = 1'b0;
                        running_next[sidx] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (dp_cmd.scan_step)
        begin
            if (hit)
            begin
                if (32'(idx_reg) < mtts_pkg::MASK_W)
                begin
                    mask_next[mtts_pkg::MASK_IW'(idx_reg)] = 1'b1;
                end
                if (periodic_reg[idx_reg])
                begin
                    reload = 1'b1;
                end
                else
                begin
                    running_next[idx_reg] = 1'b0;
                end
            end
            idx_next = idx_reg + 1'b1;
            if (dp_stat.scan_last)
            begin
                tick_next = tick_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            valid_reg    <= '0;
            running_reg  <= '0;
            periodic_reg <= '0;
            idx_reg      <= '0;
            mask_reg     <= '0;
            status_reg   <= mtts_pkg::ST_OK;
        end
        else
        begin
            tick_reg     <= tick_next;
            valid_reg    <= valid_next;
            running_reg  <= running_next;
            periodic_reg <= periodic_next;
            idx_reg      <= idx_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
        end
    end

    // read data is registered from idx_next so it matches the scan index; a reload writes the slot just checked
    always_ff @(posedge clk)
    begin
        if (wr_create)
        begin
            ivl_mem[sidx] <= ivl_reg;
            due_mem[sidx] <= '0;
        end
        else if (reload)
        begin
            due_mem[idx_reg] <= tick_reg + mtts_pkg::CNT_W'(ivl_rd_reg);
        end
        ivl_rd_reg <= ivl_mem[idx_next];
        due_rd_reg <= due_mem[idx_next];
    end

    // tick count advances only at the end of a scan
    a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.scan_step && dp_stat.scan_last) |=> $stable(tick_reg))
        else $error("tick count changed outside scan end");

    // slot commands never report fired slots
    a_cmd_mask: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.exec && !dp_stat.is_tick |=> mask_reg == '0)
        else $error("fired mask set by a slot command");

    a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg & ~valid_reg) == '0)
        else $error("running slot is not valid");

endmodule
